[rtl/dlle_pkg.sv]
// dlle_pkg: shared types and codes for the doubly linked list engine
// no dependencies
package dlle_pkg;

  localparam logic [3:0] CMD_PUSH_BACK  = 4'd0;
  localparam logic [3:0] CMD_PUSH_FRONT = 4'd1;
  localparam logic [3:0] CMD_POP_BACK   = 4'd2;
  localparam logic [3:0] CMD_POP_FRONT  = 4'd3;
  localparam logic [3:0] CMD_FIND       = 4'd4;
  localparam logic [3:0] CMD_INSERT     = 4'd5;
  localparam logic [3:0] CMD_ERASE      = 4'd6;
  localparam logic [3:0] CMD_DUMP       = 4'd7;
  localparam logic [3:0] CMD_CLEAR      = 4'd8;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_BADNODE  = 3'd4;

  typedef struct packed {
    logic [3:0]         cmd;
    logic signed [31:0] value;
    logic [6:0]         node;
  } dlle_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [6:0]         node_out;
    logic signed [31:0] value_out;
    logic               last;
  } dlle_out_t;

  // datapath operations
  localparam logic [3:0] OP_NONE      = 4'd0;
  localparam logic [3:0] OP_LATCH     = 4'd1;  // latch command and lowest free slot
  localparam logic [3:0] OP_RD_A      = 4'd2;  // read links of anchor
  localparam logic [3:0] OP_ADD_W1    = 4'd3;  // write new node, next of anchor
  localparam logic [3:0] OP_ADD_W2    = 4'd4;  // write next of new node, prev of successor
  localparam logic [3:0] OP_RM_RD     = 4'd5;  // read links of victim
  localparam logic [3:0] OP_RM_W      = 4'd6;  // unlink victim
  localparam logic [3:0] OP_WALK_RD   = 4'd7;  // read cursor
  localparam logic [3:0] OP_WALK_STEP = 4'd8;  // advance cursor
  localparam logic [3:0] OP_CLEAR     = 4'd9;

  typedef struct packed {
    logic [3:0] op;
    logic       emit;
    logic [2:0] emit_status;
    logic       emit_cur;   // emit cursor node and its value
    logic       emit_last;
  } dlle_ctl_t;

  typedef struct packed {
    logic       full;
    logic       empty;
    logic       bad_ins;
    logic       bad_era;
    logic       match;
    logic       walk_end;   // next cursor is sentinel or count reached
  } dlle_sts_t;

endpackage

[rtl/dlle_datapath.sv]
// dlle_datapath: link memories, value memory, slot map and result register
// depends on dlle_pkg
module dlle_datapath import dlle_pkg::*; #(
  parameter int POOL_NODES = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  dlle_in_t  in_item,
  input  dlle_ctl_t ctl,
  output dlle_sts_t sts,
  output logic      out_strobe,
  output dlle_out_t out_item
);
  localparam int AW = $clog2(POOL_NODES);
  localparam logic [6:0] SENT = 7'(POOL_NODES);

  logic [6:0]  next_mem [0:POOL_NODES];
  logic [6:0]  prev_mem [0:POOL_NODES];
  logic [31:0] val_mem  [0:POOL_NODES-1];
  logic [POOL_NODES-1:0] used_r;
  logic [6:0] count_r;
  logic sent_next_ok_r, sent_prev_ok_r;

  logic [3:0]  cmd_r;
  logic [31:0] val_r;
  logic [6:0]  node_r, anchor_r, cur_r, nx_r, pv_r, free_r, idx_r;
  logic [31:0] curval_r;
  logic        free_ok_r;

  // lowest free slot
  logic [6:0] free_c;
  logic free_ok_c;
  always_comb begin
    free_c = SENT;
    free_ok_c = 1'b0;
    for (int i = POOL_NODES - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_c = 7'(i);
        free_ok_c = 1'b1;
      end
    end
  end

  // sentinel links are held apart so that clear need only reset their valid flags
  logic [6:0] rd_next, rd_prev;
  logic [6:0] head_c, tail_c;
  assign head_c = sent_next_ok_r ? next_mem[POOL_NODES] : SENT;
  assign tail_c = sent_prev_ok_r ? prev_mem[POOL_NODES] : SENT;

  logic [6:0] rd_addr;
  always_comb begin
    rd_addr = anchor_r;
    unique case (ctl.op)
      OP_RM_RD:   rd_addr = anchor_r;
      OP_WALK_RD: rd_addr = cur_r;
      default:    rd_addr = anchor_r;
    endcase
  end
  assign rd_next = (rd_addr == SENT) ? head_c : next_mem[rd_addr];
  assign rd_prev = (rd_addr == SENT) ? tail_c : prev_mem[rd_addr];

  assign sts.full     = !free_ok_r;
  assign sts.empty    = (count_r == '0);
  assign sts.bad_ins  = (node_r > SENT) || ((node_r < SENT) && !used_r[node_r[AW-1:0]]);
  assign sts.bad_era  = (node_r >= SENT) || !used_r[node_r[AW-1:0]];
  assign sts.match    = (curval_r == val_r);
  assign sts.walk_end = (nx_r == SENT) || (idx_r + 7'd1 >= count_r);

  logic wr_n, wr_p;
  logic [6:0] wa_n, wd_n, wa_p, wd_p;
  always_comb begin
    wr_n = 1'b0; wa_n = '0; wd_n = '0;
    wr_p = 1'b0; wa_p = '0; wd_p = '0;
    unique case (ctl.op)
      OP_ADD_W1: begin
        wr_n = 1'b1; wa_n = anchor_r; wd_n = free_r;
        wr_p = 1'b1; wa_p = free_r;   wd_p = anchor_r;
      end
      OP_ADD_W2: begin
        wr_n = 1'b1; wa_n = free_r;   wd_n = nx_r;
        wr_p = 1'b1; wa_p = nx_r;     wd_p = free_r;
      end
      OP_RM_W: begin
        wr_n = 1'b1; wa_n = pv_r; wd_n = nx_r;
        wr_p = 1'b1; wa_p = nx_r; wd_p = pv_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_n && wa_n != SENT) next_mem[wa_n] <= wd_n;
    if (wr_n && wa_n == SENT) next_mem[POOL_NODES] <= wd_n;
    if (wr_p && wa_p != SENT) prev_mem[wa_p] <= wd_p;
    if (wr_p && wa_p == SENT) prev_mem[POOL_NODES] <= wd_p;
    if (ctl.op == OP_ADD_W1) val_mem[free_r[AW-1:0]] <= val_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.op == OP_CLEAR) begin
      used_r <= '0;
      count_r <= '0;
      sent_next_ok_r <= 1'b0;
      sent_prev_ok_r <= 1'b0;
    end else begin
      if (wr_n && wa_n == SENT) sent_next_ok_r <= 1'b1;
      if (wr_p && wa_p == SENT) sent_prev_ok_r <= 1'b1;
      if (ctl.op == OP_ADD_W1) begin
        used_r[free_r[AW-1:0]] <= 1'b1;
        count_r <= count_r + 7'd1;
      end
      if (ctl.op == OP_RM_W) begin
        used_r[anchor_r[AW-1:0]] <= 1'b0;
        count_r <= count_r - 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_LATCH: begin
        cmd_r <= in_item.cmd;
        val_r <= in_item.value;
        node_r <= in_item.node;
        free_r <= free_c;
        free_ok_r <= free_ok_c;
        idx_r <= '0;
        cur_r <= head_c;
        unique case (in_item.cmd)
          CMD_PUSH_BACK: anchor_r <= tail_c;
          CMD_PUSH_FRONT: anchor_r <= SENT;
          CMD_POP_BACK: anchor_r <= tail_c;
          CMD_POP_FRONT: anchor_r <= head_c;
          default: anchor_r <= in_item.node;
        endcase
      end
      OP_RD_A, OP_RM_RD: begin
        nx_r <= rd_next;
        pv_r <= rd_prev;
        curval_r <= val_mem[anchor_r[AW-1:0]];
      end
      OP_WALK_RD: begin
        nx_r <= rd_next;
        curval_r <= val_mem[cur_r[AW-1:0]];
      end
      OP_WALK_STEP: begin
        cur_r <= nx_r;
        idx_r <= idx_r + 7'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe <= 1'b0;
    else out_strobe <= ctl.emit;
    if (ctl.emit) begin
      out_item.status <= ctl.emit_status;
      out_item.last <= ctl.emit_last;
      if (ctl.emit_status == ST_BADNODE) begin
        out_item.node_out <= node_r;
        out_item.value_out <= '0;
      end else if (ctl.emit_status != ST_OK || cmd_r == CMD_CLEAR) begin
        out_item.node_out <= SENT;
        out_item.value_out <= '0;
      end else if (ctl.emit_cur) begin
        out_item.node_out <= cur_r;
        out_item.value_out <= curval_r;
      end else if (cmd_r == CMD_POP_BACK || cmd_r == CMD_POP_FRONT
                   || cmd_r == CMD_ERASE) begin
        out_item.node_out <= anchor_r;
        out_item.value_out <= curval_r;
      end else begin
        out_item.node_out <= free_r;
        out_item.value_out <= val_r;
      end
    end
  end
endmodule

[rtl/dlle_ctrl.sv]
// dlle_ctrl: command sequencer for the list engine
// depends on dlle_pkg
module dlle_ctrl import dlle_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic [3:0] cmd,
  input  dlle_sts_t sts,
  output logic      busy,
  output dlle_ctl_t ctl
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_ADD1 = 3'd2;
  localparam logic [2:0] S_ADD2 = 3'd3;
  localparam logic [2:0] S_RM   = 3'd4;
  localparam logic [2:0] S_WRD  = 3'd5;
  localparam logic [2:0] S_WCHK = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [3:0] cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
    if (start && !busy) cmd_r <= cmd;
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start && cmd <= CMD_CLEAR) begin
          ctl.op = OP_LATCH;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_IDLE;
        ctl.emit_last = 1'b1;
        case (cmd_r)
          CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_INSERT: begin
            if (cmd_r == CMD_INSERT && sts.bad_ins) begin
              ctl.emit = 1'b1; ctl.emit_status = ST_BADNODE;
            end else if (sts.full) begin
              ctl.emit = 1'b1; ctl.emit_status = ST_FULL;
            end else begin
              ctl.op = OP_RD_A; state_nxt = S_ADD1;
            end
          end
          CMD_POP_BACK, CMD_POP_FRONT: begin
            if (sts.empty) begin
              ctl.emit = 1'b1; ctl.emit_status = ST_EMPTY;
            end else begin
              ctl.op = OP_RM_RD; state_nxt = S_RM;
            end
          end
          CMD_ERASE: begin
            if (sts.bad_era) begin
              ctl.emit = 1'b1; ctl.emit_status = ST_BADNODE;
            end else begin
              ctl.op = OP_RM_RD; state_nxt = S_RM;
            end
          end
          CMD_FIND, CMD_DUMP: begin
            if (sts.empty) begin
              ctl.emit = 1'b1;
              ctl.emit_status = (cmd_r == CMD_FIND) ? ST_NOTFOUND : ST_EMPTY;
            end else begin
              ctl.op = OP_WALK_RD; state_nxt = S_WCHK;
            end
          end
          default: begin
            ctl.op = OP_CLEAR; ctl.emit = 1'b1; ctl.emit_status = ST_OK;
          end
        endcase
      end
      S_ADD1: begin
        ctl.op = OP_ADD_W1; state_nxt = S_ADD2;
      end
      S_ADD2: begin
        ctl.op = OP_ADD_W2; ctl.emit = 1'b1; ctl.emit_last = 1'b1;
        state_nxt = S_IDLE;
      end
      S_RM: begin
        ctl.op = OP_RM_W; ctl.emit = 1'b1; ctl.emit_last = 1'b1;
        state_nxt = S_IDLE;
      end
      S_WRD: begin
        ctl.op = OP_WALK_RD; state_nxt = S_WCHK;
      end
      S_WCHK: begin
        if (cmd_r == CMD_DUMP) begin
          ctl.emit = 1'b1; ctl.emit_cur = 1'b1; ctl.emit_last = sts.walk_end;
          ctl.op = OP_WALK_STEP;
          state_nxt = sts.walk_end ? S_IDLE : S_WRD;
        end else if (sts.match) begin
          ctl.emit = 1'b1; ctl.emit_cur = 1'b1; ctl.emit_last = 1'b1;
          state_nxt = S_IDLE;
        end else if (sts.walk_end) begin
          ctl.emit = 1'b1; ctl.emit_status = ST_NOTFOUND; ctl.emit_last = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          ctl.op = OP_WALK_STEP; state_nxt = S_WRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_emit_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |-> busy) else $error("result from idle");
  a_latch_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == OP_LATCH) |=> (state_r == S_DEC)) else $error("latch lost");
  a_add_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD1) |=> (state_r == S_ADD2)) else $error("add broken");
endmodule

[rtl/doubly_linked_list_engine_unit.sv]
// doubly_linked_list_engine_unit: top level of the list engine
// push/insert pass states DEC, ADD1, ADD2; pop/erase DEC, RM; errors and clear
// end in DEC; find and dump walk the list through the link memory
// busy stays high until the final result strobe; results cannot be stalled
// synchronous active-low reset empties the list; node memories are not cleared
// depends on dlle_pkg, dlle_ctrl, dlle_datapath
module doubly_linked_list_engine_unit import dlle_pkg::*; #(
  parameter int POOL_NODES = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  dlle_in_t  in_item,
  output logic      out_strobe,
  output dlle_out_t out_item
);
  dlle_ctl_t ctl;
  dlle_sts_t sts;

  dlle_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .cmd(in_item.cmd),
    .sts(sts), .busy(busy), .ctl(ctl)
  );

  dlle_datapath #(.POOL_NODES(POOL_NODES)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_item), .ctl(ctl), .sts(sts),
    .out_strobe(out_strobe), .out_item(out_item)
  );
endmodule
